/* hdl/pfmr_pkg.sv */
// Shared types, register indexes and the ranking comparison for the foreign-master ranker.
package pfmr_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_ANY_DOMAIN  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PREF_DOMAIN = 1'b1;

    localparam logic KIND_ANNOUNCE = 1'b0;
    localparam logic KIND_ERASE    = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [63:0] source_clock_id;
        logic [15:0] source_port_number;
        logic [63:0] grandmaster_id;
        logic [31:0] grandmaster_quality;
        logic [7:0]  priority_one;
        logic [7:0]  priority_two;
        logic [15:0] hops_received;
        logic [7:0]  header_domain;
    } in_item_t;

    typedef struct packed {
        logic        best_valid;
        logic [63:0] best_clock_id;
        logic [15:0] best_port_number;
        logic        best_changed;
        logic [3:0]  entry_count;
        logic        item_taken;
    } out_item_t;

    // One stored master; steps is the received hop count plus one.
    typedef struct packed {
        logic [63:0] clk_id;
        logic [15:0] port;
        logic [63:0] gm;
        logic [31:0] qual;
        logic [7:0]  p1;
        logic [7:0]  p2;
        logic [16:0] steps;
        logic [7:0]  dom;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic match;
        logic better;
    } eval_t;

    // True when master a ranks strictly better than master b.
    function automatic logic rank_better(entry_t a, entry_t b, logic mode, logic [7:0] pref);
        logic        ap;
        logic        bp;
        logic [17:0] as1;
        logic [17:0] bs1;
        logic        r;
        ap  = (a.dom == pref);
        bp  = (b.dom == pref);
        as1 = {1'b0, a.steps} + 18'd1;
        bs1 = {1'b0, b.steps} + 18'd1;
        if (a.gm != b.gm) begin
            if (mode && ap && !bp) begin
                r = 1'b1;
            end else if (mode && bp && !ap) begin
                r = 1'b0;
            end else if (mode && (a.dom != b.dom)) begin
                r = (a.dom < b.dom);
            end else if (a.p1 != b.p1) begin
                r = (a.p1 < b.p1);
            end else if (a.qual != b.qual) begin
                r = (a.qual < b.qual);
            end else if (a.p2 != b.p2) begin
                r = (a.p2 < b.p2);
            end else begin
                r = (a.gm < b.gm);
            end
        end else if (as1 < {1'b0, b.steps}) begin
            r = 1'b1;
        end else if ({1'b0, a.steps} > bs1) begin
            r = 1'b0;
        end else if (a.clk_id != b.clk_id) begin
            r = (a.clk_id < b.clk_id);
        end else begin
            r = (a.port < b.port);
        end
        return r;
    endfunction

endpackage

/* hdl/pfmr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pfmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/pfmr_scan.sv */
// Registered evaluation stage: compares one stored master against the request.
module pfmr_scan #(
    parameter int IW = 3,
    parameter int CW = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_v,
    input  logic [CW-1:0]     in_pos,
    input  logic [IW-1:0]     in_slot,
    input  pfmr_pkg::entry_t  stored,
    input  pfmr_pkg::entry_t  cand,
    input  logic              mode,
    input  logic [7:0]        pref,
    output logic              res_v,
    output logic [CW-1:0]     res_pos,
    output logic [IW-1:0]     res_slot,
    output pfmr_pkg::eval_t   res
);
    import pfmr_pkg::*;

    eval_t ev;

    always_comb
    begin
        ev.match  = (stored.clk_id == cand.clk_id) && (stored.port == cand.port);
        ev.better = rank_better(cand, stored, mode, pref);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_v <= 1'b0;
        end
        else
        begin
            res_v <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        res_pos  <= in_pos;
        res_slot <= in_slot;
        res      <= ev;
    end

endmodule

/* hdl/ptp_foreign_master_ranker.sv */
// Top level of the foreign-master ranker: sequencer, rank order and master table.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | into      | in_valid / in_ready  | in_data (announce or erase)
//  out     | out of    | out_valid / out_ready| out_data (best master report)
//  cfg     | into      | cfg_write            | cfg_index, cfg_data
//
// A request is handled in steps: the scan reads one table entry per cycle from the single
// RAM read port and drains a two-stage compare pipeline, then an update state and a read
// of the new best entry follow. The next request is taken once the sequencer has returned
// to idle.
// After reset the table is empty and the rank order is the identity order.
// A new request is taken while the previous result still waits in the output
// register; a stalled output holds the sequencer before it writes the result.
module ptp_foreign_master_ranker #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pfmr_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pfmr_pkg::out_item_t                 out_data,
    input  logic                                cfg_write,
    input  logic [pfmr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pfmr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pfmr_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_BEST_RD,
        ST_OUT
    } state_t;

    state_t              state_reg;
    logic                mode_reg;
    logic [7:0]          pref_reg;
    logic                kind_reg;
    entry_t              nd_reg;
    logic [IW-1:0]       rank_reg [TABLE_DEPTH];
    logic [IW-1:0]       rank_next [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic [CW-1:0]       iss_reg;
    logic                s1_v_reg;
    logic [CW-1:0]       s1_pos_reg;
    logic [IW-1:0]       s1_slot_reg;
    logic                found_reg;
    logic [CW-1:0]       found_pos_reg;
    logic [IW-1:0]       found_slot_reg;
    logic                fb_v_reg;
    logic [CW-1:0]       fb_pos_reg;
    logic                wb_reg;
    logic [IW-1:0]       worst_slot_reg;
    logic                prev_valid_reg;
    logic [IW-1:0]       prev_best_reg;
    logic                fresh_v_reg;
    logic [IW-1:0]       fresh_slot_reg;
    logic                taken_reg;
    logic                out_valid_reg;
    out_item_t           out_reg;

    logic                res_v;
    logic [CW-1:0]       res_pos;
    logic [IW-1:0]       res_slot;
    eval_t               res;
    logic [ENTRY_W-1:0]  rdata;
    entry_t              stored;
    logic [IW-1:0]       raddr;
    logic                issue;
    logic                scan_done;
    logic                out_free;

    logic                rm_en;
    logic [CW-1:0]       rm_pos;
    logic                ins_en;
    logic [CW-1:0]       ins_pos;
    logic [IW-1:0]       upd_slot;
    logic                clr_en;
    logic [IW-1:0]       free_slot;
    logic [IW-1:0]       r1 [TABLE_DEPTH];
    logic                now_valid;
    logic                changed;

    assign stored    = entry_t'(rdata);
    assign issue     = (state_reg == ST_SCAN) && (iss_reg != cnt_reg);
    assign scan_done = (state_reg == ST_SCAN) && (iss_reg == cnt_reg) && !s1_v_reg && !res_v;
    assign raddr     = issue ? rank_reg[iss_reg[IW-1:0]] : rank_reg[0];
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    pfmr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    ((state_reg == ST_UPDATE) && ins_en),
        .waddr (upd_slot),
        .wdata (nd_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    pfmr_scan #(
        .IW (IW),
        .CW (CW)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_v     (s1_v_reg),
        .in_pos   (s1_pos_reg),
        .in_slot  (s1_slot_reg),
        .stored   (stored),
        .cand     (nd_reg),
        .mode     (mode_reg),
        .pref     (pref_reg),
        .res_v    (res_v),
        .res_pos  (res_pos),
        .res_slot (res_slot),
        .res      (res)
    );

    // Lowest free slot.
    always_comb
    begin
        free_slot = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot = IW'(i);
            end
        end
    end

    // Decide the removal and insertion that the request causes.
    always_comb
    begin
        rm_en    = 1'b0;
        rm_pos   = found_pos_reg;
        ins_en   = 1'b0;
        ins_pos  = cnt_reg;
        upd_slot = found_slot_reg;
        clr_en   = 1'b0;
        if (kind_reg == KIND_ERASE)
        begin
            if (found_reg)
            begin
                rm_en  = 1'b1;
                clr_en = 1'b1;
            end
        end
        else if (found_reg)
        begin
            rm_en  = 1'b1;
            ins_en = 1'b1;
            if (!fb_v_reg)
            begin
                ins_pos = cnt_reg - 1'b1;
            end
            else if (fb_pos_reg > found_pos_reg)
            begin
                ins_pos = fb_pos_reg - 1'b1;
            end
            else
            begin
                ins_pos = fb_pos_reg;
            end
        end
        else if (cnt_reg != FULL_CNT)
        begin
            ins_en   = 1'b1;
            upd_slot = free_slot;
            ins_pos  = fb_v_reg ? fb_pos_reg : cnt_reg;
        end
        else if (wb_reg)
        begin
            // Evict the worst entry and reuse its slot for the new master.
            rm_en    = 1'b1;
            rm_pos   = cnt_reg - 1'b1;
            ins_en   = 1'b1;
            ins_pos  = fb_pos_reg;
            upd_slot = worst_slot_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            r1[i] = rank_reg[i];
        end
        for (int i = 0; i < TABLE_DEPTH - 1; i++)
        begin
            if (rm_en && (i >= int'(rm_pos)))
            begin
                r1[i] = rank_reg[i + 1];
            end
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            rank_next[i] = r1[i];
            if (ins_en && (i == int'(ins_pos)))
            begin
                rank_next[i] = upd_slot;
            end
            else if (ins_en && (i > int'(ins_pos)))
            begin
                rank_next[i] = r1[i - 1];
            end
        end
        valid_next = valid_reg;
        if (clr_en)
        begin
            valid_next[upd_slot] = 1'b0;
        end
        if (ins_en)
        begin
            valid_next[upd_slot] = 1'b1;
        end
        cnt_next = cnt_reg - CW'(rm_en) + CW'(ins_en);
    end

    assign now_valid = (cnt_reg != '0);

    always_comb
    begin
        if (now_valid != prev_valid_reg)
        begin
            changed = 1'b1;
        end
        else if (!now_valid)
        begin
            changed = 1'b0;
        end
        else
        begin
            changed = (rank_reg[0] != prev_best_reg) ||
                      (fresh_v_reg && (rank_reg[0] == fresh_slot_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b0;
            pref_reg      <= '0;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            iss_reg       <= '0;
            s1_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                rank_reg[i] <= IW'(i);
            end
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ANY_DOMAIN:  mode_reg <= cfg_data[0];
                    CFG_PREF_DOMAIN: pref_reg <= cfg_data;
                    default:         ;
                endcase
            end
            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            s1_v_reg <= issue;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        iss_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (issue)
                    begin
                        iss_reg <= iss_reg + 1'b1;
                    end
                    if (scan_done)
                    begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    rank_reg  <= rank_next;
                    valid_reg <= valid_next;
                    cnt_reg   <= cnt_next;
                    state_reg <= ST_BEST_RD;
                end
                ST_BEST_RD:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Request payload and scan bookkeeping.
    always_ff @(posedge clk)
    begin
        s1_pos_reg  <= iss_reg;
        s1_slot_reg <= raddr;
        if (state_reg == ST_IDLE)
        begin
            kind_reg              <= in_data.kind;
            nd_reg.clk_id         <= in_data.source_clock_id;
            nd_reg.port           <= in_data.source_port_number;
            nd_reg.gm             <= in_data.grandmaster_id;
            nd_reg.qual           <= in_data.grandmaster_quality;
            nd_reg.p1             <= in_data.priority_one;
            nd_reg.p2             <= in_data.priority_two;
            nd_reg.steps          <= {1'b0, in_data.hops_received} + 17'd1;
            nd_reg.dom            <= in_data.header_domain;
            prev_valid_reg        <= (cnt_reg != '0);
            prev_best_reg         <= rank_reg[0];
            found_reg             <= 1'b0;
            fb_v_reg              <= 1'b0;
            wb_reg                <= 1'b0;
        end
        if (res_v)
        begin
            if (res.match)
            begin
                found_reg      <= 1'b1;
                found_pos_reg  <= res_pos;
                found_slot_reg <= res_slot;
            end
            else if (res.better && !fb_v_reg)
            begin
                fb_v_reg   <= 1'b1;
                fb_pos_reg <= res_pos;
            end
            if (res_pos == cnt_reg - 1'b1)
            begin
                worst_slot_reg <= res_slot;
                wb_reg         <= res.better && !res.match;
            end
        end
        if (state_reg == ST_UPDATE)
        begin
            taken_reg      <= ins_en || clr_en;
            fresh_v_reg    <= ins_en && !found_reg;
            fresh_slot_reg <= upd_slot;
        end
        if ((state_reg == ST_OUT) && out_free)
        begin
            out_reg.best_valid       <= now_valid;
            out_reg.best_clock_id    <= now_valid ? stored.clk_id : 64'd0;
            out_reg.best_port_number <= now_valid ? stored.port : 16'd0;
            out_reg.best_changed     <= changed;
            out_reg.entry_count      <= 4'(cnt_reg);
            out_reg.item_taken       <= taken_reg;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("stored master count exceeds the table depth");

    a_valid_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(cnt_reg))
        else $error("slot valid bits disagree with the stored count");

    a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        res_v |-> (state_reg == ST_SCAN))
        else $error("comparison result outside the scan phase");

    a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.best_valid) |->
            (out_reg.best_clock_id == 64'd0 && out_reg.entry_count == 4'd0))
        else $error("empty table reported with a best master");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the foreign-master ranker: directed table plus random requests.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pfmr_pkg::*;

    localparam int DEPTH = 8;
    localparam int RANDOM_REQUESTS = 540;
    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic [63:0] clk_id;
        logic [15:0] port;
        logic [63:0] gm;
        logic [31:0] qual;
        logic [7:0]  p1;
        logic [7:0]  p2;
        logic [16:0] steps;
        logic [7:0]  dom;
    } master_t;

    typedef struct {
        in_item_t  req;
        logic      has_expect;
        out_item_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor state.
    master_t masters[DEPTH];
    logic    slot_used[DEPTH];
    int      rank_slot[DEPTH];
    int      stored;
    logic    mode_any;
    logic [7:0] pref_dom;

    out_item_t reports_due[$];
    int errors;
    int reports_seen;
    int idle_cycles;
    bit timed_out;
    logic [63:0] id_pool[4];
    logic [63:0] gm_pool[3];

    ptp_foreign_master_ranker #(.TABLE_DEPTH(DEPTH)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic ranks_ahead(master_t a, master_t b);
        if (a.gm != b.gm)
        begin
            if (mode_any)
            begin
                if (a.dom == pref_dom && b.dom != pref_dom) return 1'b1;
                if (b.dom == pref_dom && a.dom != pref_dom) return 1'b0;
                if (a.dom != b.dom) return a.dom < b.dom;
            end
            if (a.p1 != b.p1) return a.p1 < b.p1;
            if (a.qual != b.qual) return a.qual < b.qual;
            if (a.p2 != b.p2) return a.p2 < b.p2;
            return a.gm < b.gm;
        end
        if ({1'b0, a.steps} + 18'd1 < {1'b0, b.steps}) return 1'b1;
        if ({1'b0, a.steps} > {1'b0, b.steps} + 18'd1) return 1'b0;
        if (a.clk_id != b.clk_id) return a.clk_id < b.clk_id;
        return a.port < b.port;
    endfunction

    function automatic void drop_rank(int pos);
        int s;
        s = rank_slot[pos];
        for (int i = pos; i + 1 < stored; i++) rank_slot[i] = rank_slot[i + 1];
        rank_slot[stored - 1] = s;
        stored--;
    endfunction

    function automatic void place_rank(int s);
        int pos;
        pos = stored;
        for (int i = 0; i < stored; i++)
        begin
            if (ranks_ahead(masters[s], masters[rank_slot[i]]))
            begin
                pos = i;
                break;
            end
        end
        for (int i = stored; i > pos; i--) rank_slot[i] = rank_slot[i - 1];
        rank_slot[pos] = s;
        stored++;
    endfunction

    function automatic out_item_t predict_best(in_item_t r);
        master_t nd;
        out_item_t o;
        logic was_valid;
        int was_best;
        int fresh;
        int pos;
        int s;
        int worst;
        logic hit;
        logic took;
        nd.clk_id = r.source_clock_id;
        nd.port = r.source_port_number;
        nd.gm = r.grandmaster_id;
        nd.qual = r.grandmaster_quality;
        nd.p1 = r.priority_one;
        nd.p2 = r.priority_two;
        nd.steps = {1'b0, r.hops_received} + 17'd1;
        nd.dom = r.header_domain;
        was_valid = stored > 0;
        was_best = was_valid ? rank_slot[0] : 0;
        fresh = -1;
        hit = 1'b0;
        took = 1'b0;
        pos = 0;
        for (int i = 0; i < stored; i++)
        begin
            if (masters[rank_slot[i]].clk_id == nd.clk_id && masters[rank_slot[i]].port == nd.port)
            begin
                hit = 1'b1;
                pos = i;
                break;
            end
        end
        if (r.kind == KIND_ERASE)
        begin
            if (hit)
            begin
                s = rank_slot[pos];
                drop_rank(pos);
                slot_used[s] = 1'b0;
                took = 1'b1;
            end
        end
        else if (hit)
        begin
            s = rank_slot[pos];
            masters[s] = nd;
            drop_rank(pos);
            place_rank(s);
            took = 1'b1;
        end
        else
        begin
            if (stored >= DEPTH)
            begin
                worst = rank_slot[stored - 1];
                if (ranks_ahead(nd, masters[worst]))
                begin
                    drop_rank(stored - 1);
                    slot_used[worst] = 1'b0;
                end
            end
            if (stored < DEPTH)
            begin
                s = 0;
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (!slot_used[i])
                    begin
                        s = i;
                        break;
                    end
                end
                masters[s] = nd;
                slot_used[s] = 1'b1;
                place_rank(s);
                fresh = s;
                took = 1'b1;
            end
        end
        o.best_valid = stored > 0;
        o.best_clock_id = (stored > 0) ? masters[rank_slot[0]].clk_id : 64'd0;
        o.best_port_number = (stored > 0) ? masters[rank_slot[0]].port : 16'd0;
        if (o.best_valid != was_valid) o.best_changed = 1'b1;
        else if (!o.best_valid) o.best_changed = 1'b0;
        else o.best_changed = (rank_slot[0] != was_best) || (rank_slot[0] == fresh);
        o.entry_count = stored[3:0];
        o.item_taken = took;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // Result checker with random stall on the output side.
    initial
    begin
        int wait_n;
        out_item_t w;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            repeat (wait_n) @(negedge clk);
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            if (reports_due.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                errors++;
            end
            else
            begin
                w = reports_due.pop_front();
                if (out_data.best_valid != w.best_valid)
                    report_mismatch("best_valid", out_data.best_valid, w.best_valid);
                if (out_data.best_clock_id != w.best_clock_id)
                    report_mismatch("best_clock_id", out_data.best_clock_id, w.best_clock_id);
                if (out_data.best_port_number != w.best_port_number)
                    report_mismatch("best_port_number", out_data.best_port_number,
                                    w.best_port_number);
                if (out_data.best_changed != w.best_changed)
                    report_mismatch("best_changed", out_data.best_changed, w.best_changed);
                if (out_data.entry_count != w.entry_count)
                    report_mismatch("entry_count", out_data.entry_count, w.entry_count);
                if (out_data.item_taken != w.item_taken)
                    report_mismatch("item_taken", out_data.item_taken, w.item_taken);
            end
            reports_seen++;
            @(negedge clk);
            out_ready = 1'b0;
        end
    end

    // Watchdog: counts cycles with no handshake on either the request or the result channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        @(posedge clk);
        wait (idle_cycles >= STALL_LIMIT);
        timed_out = 1'b1;
        $display("watchdog expired, no handshake for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == CFG_ANY_DOMAIN) mode_any = val[0];
        else pref_dom = val;
    endtask

    task automatic drain_results();
        wait (reports_due.size() == 0);
        repeat (30) @(negedge clk);
    endtask

    // Sends one request; where no expected value is typed in, the predictor supplies it.
    task automatic send_request(in_item_t r, logic has_expect, out_item_t want);
        out_item_t p;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        repeat (gap) @(negedge clk);
        p = predict_best(r);
        if (has_expect && p != want)
        begin
            $display("typed expectation disagrees with predictor at %0t", $realtime);
            errors++;
        end
        in_data = r;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        reports_due.push_back(has_expect ? want : p);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic in_item_t make_announce(logic [63:0] cid, logic [15:0] pn,
                                               logic [63:0] gm, logic [31:0] q,
                                               logic [7:0] p1, logic [7:0] p2,
                                               logic [15:0] hops, logic [7:0] dom);
        in_item_t r;
        r = '{KIND_ANNOUNCE, cid, pn, gm, q, p1, p2, hops, dom};
        return r;
    endfunction

    function automatic in_item_t make_erase(logic [63:0] cid, logic [15:0] pn);
        in_item_t r;
        r = in_item_t'($urandom);
        r.kind = KIND_ERASE;
        r.source_clock_id = cid;
        r.source_port_number = pn;
        return r;
    endfunction

    function automatic in_item_t random_request();
        in_item_t r;
        r = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom});
        r.kind = ($urandom_range(0, 4) == 0) ? KIND_ERASE : KIND_ANNOUNCE;
        // Mostly reuse a small set of identities so updates, erases and evictions happen.
        if ($urandom_range(0, 5) != 0)
        begin
            r.source_clock_id = id_pool[$urandom_range(0, 3)];
            r.source_port_number = 16'($urandom_range(0, 3));
        end
        if ($urandom_range(0, 2) != 0) r.grandmaster_id = gm_pool[$urandom_range(0, 2)];
        if ($urandom_range(0, 1) != 0) r.grandmaster_quality = 32'($urandom_range(0, 2));
        if ($urandom_range(0, 1) != 0) r.priority_one = 8'($urandom_range(127, 128));
        if ($urandom_range(0, 1) != 0) r.priority_two = 8'($urandom_range(0, 1));
        if ($urandom_range(0, 1) != 0) r.hops_received = 16'($urandom_range(0, 4));
        else if (r.hops_received == 16'hFFFF) r.hops_received = 16'hFFFE;
        if ($urandom_range(0, 1) != 0) r.header_domain = 8'($urandom_range(0, 2));
        return r;
    endfunction

    initial
    begin
        stim_row_t rows[$];
        stim_row_t row;
        out_item_t none;
        logic [63:0] ones;
        ones = '1;
        none = '0;
        errors = 0;
        reports_seen = 0;
        timed_out = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_ANY_DOMAIN;
        cfg_data = '0;
        mode_any = 1'b0;
        pref_dom = 8'd0;
        stored = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_used[i] = 1'b0;
            rank_slot[i] = i;
            masters[i] = '{default: '0};
        end
        for (int i = 0; i < 4; i++) id_pool[i] = {$urandom, $urandom};
        id_pool[0] = '0;
        id_pool[1] = ones;
        for (int i = 0; i < 3; i++) gm_pool[i] = {$urandom, $urandom};
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Directed table: erase on empty, extremes, update, eviction and its refusal.
        rows.push_back('{make_erase(64'd5, 16'd1), 1'b1, '{0, 0, 0, 0, 4'd0, 0}});
        rows.push_back('{make_announce(ones, 16'hFFFF, ones, '1, 8'hFF, 8'hFF, 16'hFFFE, 8'hFF),
                         1'b1, '{1, ones, 16'hFFFF, 1, 4'd1, 1}});
        rows.push_back('{make_announce(64'd0, 16'd0, 64'd0, 32'd0, 8'd0, 8'd0, 16'd0, 8'd0),
                         1'b1, '{1, 64'd0, 16'd0, 1, 4'd2, 1}});
        // Same grandmaster, steps within tolerance: port identity decides.
        rows.push_back('{make_announce(64'd9, 16'd2, 64'd0, 32'd5, 8'd3, 8'd3, 16'd1, 8'd1),
                         1'b0, none});
        rows.push_back('{make_announce(64'd9, 16'd3, 64'd0, 32'd5, 8'd3, 8'd3, 16'd2, 8'd1),
                         1'b0, none});
        // Same grandmaster, steps far apart: fewer steps wins over identity.
        rows.push_back('{make_announce(64'd0, 16'd0, 64'd0, 32'd0, 8'd0, 8'd0, 16'd10, 8'd0),
                         1'b0, none});
        rows.push_back('{make_announce(64'd7, 16'd1, 64'd4, 32'd1, 8'd1, 8'd1, 16'd0, 8'd7),
                         1'b0, none});
        rows.push_back('{make_announce(64'd8, 16'd1, 64'd5, 32'd1, 8'd1, 8'd0, 16'd0, 8'd7),
                         1'b0, none});
        rows.push_back('{make_announce(64'd10, 16'd1, 64'd6, 32'd0, 8'd1, 8'd1, 16'd0, 8'd7),
                         1'b0, none});
        rows.push_back('{make_announce(64'd11, 16'd1, 64'd3, 32'd1, 8'd1, 8'd1, 16'd0, 8'd7),
                         1'b0, none});
        rows.push_back('{make_announce(64'd12, 16'd1, 64'd2, 32'd9, 8'd2, 8'd1, 16'd0, 8'd7),
                         1'b0, none});
        // Table is full now; a worse master is refused, a better one evicts the worst.
        rows.push_back('{make_announce(64'd13, 16'd1, 64'd99, '1, 8'hFF, 8'hFF, 16'd0, 8'd7),
                         1'b0, none});
        rows.push_back('{make_announce(64'd14, 16'd1, 64'd1, 32'd0, 8'd0, 8'd0, 16'd0, 8'd7),
                         1'b0, none});
        rows.push_back('{make_erase(64'd14, 16'd1), 1'b0, none});
        rows.push_back('{make_erase(64'd0, 16'd0), 1'b0, none});
        rows.push_back('{make_erase(64'd77, 16'd0), 1'b0, none});
        foreach (rows[i])
        begin
            row = rows[i];
            send_request(row.req, row.has_expect, row.want);
        end
        drain_results();

        // Random phases through the register settings, extremes included.
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(CFG_ANY_DOMAIN, (ph == 0) ? 8'd0 : 8'd1);
            write_reg(CFG_PREF_DOMAIN, (ph == 1) ? 8'd0 : (ph == 2) ? 8'hFF : 8'd1);
            for (int n = 0; n < RANDOM_REQUESTS / 4; n++)
                send_request(random_request(), 1'b0, none);
            drain_results();
        end

        $display("covered %0d results over four register settings, directed and random",
                 reports_seen);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

/* files.f */
hdl/pfmr_pkg.sv
hdl/pfmr_ram.sv
hdl/pfmr_scan.sv
hdl/ptp_foreign_master_ranker.sv
sim/testbench.sv
